/* src/camt_pkg.sv */
`timescale 1ns / 1ps
package camt_pkg;

    localparam int MAX_POINTS_DEF   = 4096;
    localparam int CORDIC_STEPS_DEF = 18;
    localparam int IDX_W            = 12;
    localparam int RADIUS_W         = 24;

    // CORDIC gain K in Q30
    localparam logic [30:0] GAIN_Q30 = 31'd1768195363;
    localparam logic [30:0] ONE_Q30  = 31'h4000_0000;

    typedef struct packed {
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic signed [31:0] pos_z;
        logic               last_point;
    } t_in_item;

    typedef struct packed {
        logic signed [19:0] max_angle;
        logic signed [31:0] best_x;
        logic signed [31:0] best_y;
        logic signed [31:0] best_z;
        logic [IDX_W-1:0]   best_index;
        logic               reused_previous;
        logic               result_valid;
    } t_out_item;

    // classified request handed from front to back
    typedef struct packed {
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic signed [31:0] pos_z;
        logic [IDX_W-1:0]   index;
        logic               point_ok;
        logic               last;
    } t_job;

    typedef struct packed {
        logic signed [19:0] angle;
        logic signed [31:0] x;
        logic signed [31:0] y;
        logic signed [31:0] z;
        logic [IDX_W-1:0]   index;
    } t_best;

    typedef enum logic [3:0] {
        A_IDLE, A_CORD1, A_MUL, A_DIVI, A_DIV, A_DQ, A_SQR, A_SQRT, A_CORD2, A_SUM, A_DONE
    } t_ang_state;

    typedef enum logic {
        B_IDLE, B_BUSY
    } t_back_state;

    // arctangent of 2^-i in Q30
    function automatic logic [30:0] atan_entry(input logic [4:0] i);
        logic [30:0] v;
        unique case (i)
            5'd0:    v = 31'd843314857;
            5'd1:    v = 31'd497837829;
            5'd2:    v = 31'd263043837;
            5'd3:    v = 31'd133525159;
            5'd4:    v = 31'd67021687;
            5'd5:    v = 31'd33543516;
            5'd6:    v = 31'd16775851;
            5'd7:    v = 31'd8388437;
            5'd8:    v = 31'd4194283;
            5'd9:    v = 31'd2097149;
            default: v = ONE_Q30 >> i;
        endcase
        return v;
    endfunction

endpackage

/* src/camt_front.sv */
`timescale 1ns / 1ps
module camt_front #(
    parameter int MAX_POINTS = camt_pkg::MAX_POINTS_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               push,
    input  camt_pkg::t_in_item i_in_item,
    output logic               full,
    output camt_pkg::t_job     o_job,
    output logic               o_job_valid,
    input  logic               i_job_pop
);
    localparam int CNT_W = (MAX_POINTS > 2) ? $clog2(MAX_POINTS) : 1;
    localparam int IDX_W = camt_pkg::IDX_W;

    logic [CNT_W-1:0]       r_cnt, n_cnt;
    camt_pkg::t_job         r_q [2];
    logic                   r_wp, r_rp;
    logic [1:0]             r_count;
    logic                   acc;
    camt_pkg::t_job         job_in;
    logic [CNT_W+IDX_W-1:0] idx_ext;

    assign full        = (r_count == 2'd2);
    assign acc         = push && !full;
    assign o_job_valid = (r_count != 2'd0);
    assign o_job       = r_q[r_rp];
    assign idx_ext     = {{IDX_W{1'b0}}, r_cnt};

    always_comb begin
        job_in.pos_x    = i_in_item.pos_x;
        job_in.pos_y    = i_in_item.pos_y;
        job_in.pos_z    = i_in_item.pos_z;
        job_in.index    = idx_ext[IDX_W-1:0];
        job_in.last     = i_in_item.last_point;
        // skip negative x and the origin
        job_in.point_ok = !i_in_item.pos_x[31] &&
                          !(i_in_item.pos_x == 32'sd0 && i_in_item.pos_z == 32'sd0);
        if (i_in_item.last_point) begin
            n_cnt = '0;
        end else if (r_cnt != CNT_W'(MAX_POINTS - 1)) begin
            n_cnt = r_cnt + 1'b1;
        end else begin
            n_cnt = r_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt   <= '0;
            r_wp    <= 1'b0;
            r_rp    <= 1'b0;
            r_count <= '0;
        end else begin
            if (acc) begin
                r_cnt    <= n_cnt;
                r_q[r_wp] <= job_in;
                r_wp     <= !r_wp;
            end
            if (i_job_pop) begin
                r_rp <= !r_rp;
            end
            r_count <= r_count + {1'b0, acc} - {1'b0, i_job_pop};
        end
    end

    a_count_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= 2'd2) else $error("job queue overflow");

endmodule

/* src/camt_angle.sv */
`timescale 1ns / 1ps
module camt_angle #(
    parameter int CORDIC_STEPS = camt_pkg::CORDIC_STEPS_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_start,
    input  logic signed [31:0]                i_x,
    input  logic signed [31:0]                i_z,
    input  logic [camt_pkg::RADIUS_W-1:0]     i_radius,
    output logic                              o_done,
    output logic signed [19:0]                o_angle
);
    camt_pkg::t_ang_state r_state, n_state;
    logic [5:0]           r_cnt, n_cnt;
    logic signed [35:0]   r_a, n_a, r_b, n_b, r_m, n_m;
    logic signed [33:0]   r_ang, n_ang, r_phi1, n_phi1;
    logic [54:0]          r_num, n_num;
    logic [35:0]          r_rem, n_rem;
    logic [31:0]          r_quot, n_quot;
    logic [30:0]          r_q, n_q;
    logic [61:0]          r_rad, n_rad;
    logic [30:0]          r_root, n_root;
    logic [32:0]          r_srem, n_srem;
    logic signed [19:0]   r_angle, n_angle;

    logic [4:0]           sh;
    logic signed [35:0]   ca, cb;
    logic signed [33:0]   cang, e;
    logic                 cord_last;
    logic [35:0]          hi, trial;
    logic [31:0]          num_lo;
    logic [61:0]          qsq;
    logic [34:0]          snrem, strial;
    logic [30:0]          root_nx;
    logic signed [34:0]   ssum;
    logic signed [20:0]   sround;

    // one CORDIC rotation, shared by both passes
    always_comb begin
        sh        = r_cnt[4:0];
        e         = $signed({3'b000, camt_pkg::atan_entry(sh)});
        cord_last = (r_cnt == 6'(CORDIC_STEPS - 1));
        if (!r_b[35]) begin
            ca   = r_a + (r_b >>> sh);
            cb   = r_b - (r_a >>> sh);
            cang = r_ang + e;
        end else begin
            ca   = r_a - (r_b >>> sh);
            cb   = r_b + (r_a >>> sh);
            cang = r_ang - e;
        end
    end

    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        n_a     = r_a;
        n_b     = r_b;
        n_m     = r_m;
        n_ang   = r_ang;
        n_phi1  = r_phi1;
        n_num   = r_num;
        n_rem   = r_rem;
        n_quot  = r_quot;
        n_q     = r_q;
        n_rad   = r_rad;
        n_root  = r_root;
        n_srem  = r_srem;
        n_angle = r_angle;
        o_done  = 1'b0;

        hi      = 36'(r_num[54:32]);
        num_lo  = r_num[31:0];
        trial   = {r_rem[34:0], num_lo[sh]};
        qsq     = 62'(r_q * r_q);
        snrem   = {r_srem, r_rad[61:60]};
        strial  = 35'({r_root, 2'b01});
        root_nx = (snrem >= strial) ? {r_root[29:0], 1'b1} : {r_root[29:0], 1'b0};
        ssum    = 35'(r_phi1) + 35'(r_ang) + 35'sd8192;
        sround  = 21'(ssum >>> 14);

        unique case (r_state)
            camt_pkg::A_IDLE: begin
                if (i_start) begin
                    n_a     = 36'(i_x);
                    n_b     = 36'(i_z);
                    n_ang   = '0;
                    n_cnt   = '0;
                    n_state = camt_pkg::A_CORD1;
                end
            end
            camt_pkg::A_CORD1: begin
                n_a   = ca;
                n_b   = cb;
                n_ang = cang;
                n_cnt = r_cnt + 1'b1;
                if (cord_last) begin
                    n_phi1  = cang;
                    n_m     = ca;
                    n_state = camt_pkg::A_MUL;
                end
            end
            camt_pkg::A_MUL: begin
                n_num   = 55'(i_radius * camt_pkg::GAIN_Q30);
                n_state = camt_pkg::A_DIVI;
            end
            camt_pkg::A_DIVI: begin
                // quotient would reach 2^32 or magnitude is not positive: saturate
                if (r_m[35] || r_m == 36'sd0 || hi >= 36'(r_m)) begin
                    n_q     = camt_pkg::ONE_Q30;
                    n_state = camt_pkg::A_SQR;
                end else begin
                    n_rem   = hi;
                    n_quot  = '0;
                    n_cnt   = 6'd31;
                    n_state = camt_pkg::A_DIV;
                end
            end
            camt_pkg::A_DIV: begin
                if (trial >= 36'(r_m)) begin
                    n_rem  = trial - 36'(r_m);
                    n_quot = {r_quot[30:0], 1'b1};
                end else begin
                    n_rem  = trial;
                    n_quot = {r_quot[30:0], 1'b0};
                end
                n_cnt = r_cnt - 1'b1;
                if (r_cnt == 6'd0) begin
                    n_state = camt_pkg::A_DQ;
                end
            end
            camt_pkg::A_DQ: begin
                n_q     = (r_quot > 32'(camt_pkg::ONE_Q30)) ? camt_pkg::ONE_Q30 : r_quot[30:0];
                n_state = camt_pkg::A_SQR;
            end
            camt_pkg::A_SQR: begin
                n_rad   = {2'b01, 60'd0} - qsq;
                n_root  = '0;
                n_srem  = '0;
                n_cnt   = 6'd30;
                n_state = camt_pkg::A_SQRT;
            end
            camt_pkg::A_SQRT: begin
                // one result bit per cycle, two radicand bits consumed
                n_srem = (snrem >= strial) ? 33'(snrem - strial) : 33'(snrem);
                n_root = root_nx;
                n_rad  = {r_rad[59:0], 2'b00};
                n_cnt  = r_cnt - 1'b1;
                if (r_cnt == 6'd0) begin
                    n_a     = 36'(root_nx);
                    n_b     = 36'(r_q);
                    n_ang   = '0;
                    n_cnt   = '0;
                    n_state = camt_pkg::A_CORD2;
                end
            end
            camt_pkg::A_CORD2: begin
                n_a   = ca;
                n_b   = cb;
                n_ang = cang;
                n_cnt = r_cnt + 1'b1;
                if (cord_last) begin
                    n_state = camt_pkg::A_SUM;
                end
            end
            camt_pkg::A_SUM: begin
                if (sround > 21'sd524287) begin
                    n_angle = 20'sh7FFFF;
                end else if (sround < -21'sd524288) begin
                    n_angle = 20'sh80000;
                end else begin
                    n_angle = sround[19:0];
                end
                n_state = camt_pkg::A_DONE;
            end
            camt_pkg::A_DONE: begin
                o_done  = 1'b1;
                n_state = camt_pkg::A_IDLE;
            end
            default: n_state = camt_pkg::A_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= camt_pkg::A_IDLE;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
        r_a     <= n_a;
        r_b     <= n_b;
        r_m     <= n_m;
        r_ang   <= n_ang;
        r_phi1  <= n_phi1;
        r_num   <= n_num;
        r_rem   <= n_rem;
        r_quot  <= n_quot;
        r_q     <= n_q;
        r_rad   <= n_rad;
        r_root  <= n_root;
        r_srem  <= n_srem;
        r_angle <= n_angle;
    end

    assign o_angle = r_angle;

    a_start_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_start |-> r_state == camt_pkg::A_IDLE) else $error("start while busy");

endmodule

/* src/camt_back.sv */
`timescale 1ns / 1ps
module camt_back (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  camt_pkg::t_job      i_job,
    input  logic                i_job_valid,
    output logic                o_job_pop,
    output logic                o_ang_start,
    output logic signed [31:0]  o_ang_x,
    output logic signed [31:0]  o_ang_z,
    input  logic                i_ang_done,
    input  logic signed [19:0]  i_ang,
    output camt_pkg::t_out_item o_out_item,
    output logic                empty,
    input  logic                pop
);
    camt_pkg::t_back_state r_state, n_state;
    camt_pkg::t_job        r_job, n_job;
    camt_pkg::t_best       r_run, n_run, r_prev, n_prev, f_best;
    logic                  r_run_have, n_run_have, r_prev_valid, n_prev_valid;
    camt_pkg::t_out_item   r_out, n_out;
    logic                  r_out_full, n_out_full;
    logic                  fin, f_have;

    assign o_ang_x    = i_job.pos_x;
    assign o_ang_z    = i_job.pos_z;
    assign o_out_item = r_out;
    assign empty      = !r_out_full;

    always_comb begin
        n_state      = r_state;
        n_job        = r_job;
        n_run        = r_run;
        n_run_have   = r_run_have;
        n_prev       = r_prev;
        n_prev_valid = r_prev_valid;
        n_out        = r_out;
        n_out_full   = r_out_full && !pop;
        o_job_pop    = 1'b0;
        o_ang_start  = 1'b0;
        fin          = 1'b0;
        f_have       = r_run_have;
        f_best       = r_run;

        unique case (r_state)
            camt_pkg::B_IDLE: begin
                // a closing request waits until the result slot is free
                if (i_job_valid && (!i_job.last || !r_out_full)) begin
                    o_job_pop = 1'b1;
                    n_job     = i_job;
                    if (i_job.point_ok) begin
                        o_ang_start = 1'b1;
                        n_state     = camt_pkg::B_BUSY;
                    end else begin
                        fin = i_job.last;
                    end
                end
            end
            camt_pkg::B_BUSY: begin
                if (i_ang_done) begin
                    if (!r_run_have || i_ang > r_run.angle) begin
                        f_best.angle = i_ang;
                        f_best.x     = r_job.pos_x;
                        f_best.y     = r_job.pos_y;
                        f_best.z     = r_job.pos_z;
                        f_best.index = r_job.index;
                    end
                    f_have     = 1'b1;
                    n_run      = f_best;
                    n_run_have = 1'b1;
                    fin        = r_job.last;
                    n_state    = camt_pkg::B_IDLE;
                end
            end
            default: n_state = camt_pkg::B_IDLE;
        endcase

        if (fin) begin
            n_out_full = 1'b1;
            if (f_have) begin
                n_prev       = f_best;
                n_prev_valid = 1'b1;
                n_out        = {f_best.angle, f_best.x, f_best.y, f_best.z, f_best.index,
                                1'b0, 1'b1};
            end else if (r_prev_valid) begin
                n_out = {r_prev.angle, r_prev.x, r_prev.y, r_prev.z, r_prev.index,
                         1'b1, 1'b1};
            end else begin
                n_out = '0;
            end
            n_run      = '0;
            n_run_have = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= camt_pkg::B_IDLE;
            r_run        <= '0;
            r_run_have   <= 1'b0;
            r_prev       <= '0;
            r_prev_valid <= 1'b0;
            r_out_full   <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_run        <= n_run;
            r_run_have   <= n_run_have;
            r_prev       <= n_prev;
            r_prev_valid <= n_prev_valid;
            r_out_full   <= n_out_full;
        end
        r_job <= n_job;
        r_out <= n_out;
    end

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        fin |-> !r_out_full) else $error("result overwritten");

    a_done_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_ang_done |-> r_state == camt_pkg::B_BUSY) else $error("stray angle done");

endmodule

/* src/contact_angle_max_tracker.sv */
`timescale 1ns / 1ps
// Contact angle max tracker. Points of a set arrive one per push request; for every point
// with x >= 0 (origin excluded) the contact angle atan2(z,x) + asin(min(R/|(x,z)|,1)) is
// computed in Q3.16 radians, and on the request flagged last_point one result appears
// with the largest angle of the set, its point and its index (first wins on a tie). A
// set without a usable point repeats the previous result with reused_previous set, or
// gives result_valid low if there never was one. Each usable point passes through one
// iterative angle unit in turn: a vectoring CORDIC pass, a bit-serial 32-step divide, a
// 31-step integer square root and a second CORDIC pass; when R/d saturates, the divide
// is skipped. Skipped points bypass the angle unit. A two-entry request queue sits
// ahead of the angle unit, and the result waits in a one-entry output slot until
// popped; the closing request of the next set stalls only while that slot is still
// full. contact_radius (Q8.16) is written through i_cfg_we and should change only
// while the block is idle.
module contact_angle_max_tracker #(
    parameter int MAX_POINTS   = camt_pkg::MAX_POINTS_DEF,
    parameter int CORDIC_STEPS = camt_pkg::CORDIC_STEPS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          push,
    input  camt_pkg::t_in_item            i_in_item,
    output logic                          full,
    output camt_pkg::t_out_item           o_out_item,
    output logic                          empty,
    input  logic                          pop,
    input  logic                          i_cfg_we,
    input  logic [camt_pkg::RADIUS_W-1:0] i_cfg_data
);
    logic [camt_pkg::RADIUS_W-1:0] r_radius;
    camt_pkg::t_job                job;
    logic                          job_valid, job_pop;
    logic                          ang_start, ang_done;
    logic signed [31:0]            ang_x, ang_z;
    logic signed [19:0]            ang;

    // wheel radius register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_radius <= '0;
        end else if (i_cfg_we) begin
            r_radius <= i_cfg_data;
        end
    end

    // front: index counting, point classification, request queue
    camt_front #(.MAX_POINTS(MAX_POINTS)) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .push        (push),
        .i_in_item   (i_in_item),
        .full        (full),
        .o_job       (job),
        .o_job_valid (job_valid),
        .i_job_pop   (job_pop)
    );

    // back: running maximum, history and result slot
    camt_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_job       (job),
        .i_job_valid (job_valid),
        .o_job_pop   (job_pop),
        .o_ang_start (ang_start),
        .o_ang_x     (ang_x),
        .o_ang_z     (ang_z),
        .i_ang_done  (ang_done),
        .i_ang       (ang),
        .o_out_item  (o_out_item),
        .empty       (empty),
        .pop         (pop)
    );

    // shared iterative angle unit
    camt_angle #(.CORDIC_STEPS(CORDIC_STEPS)) u_angle (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (ang_start),
        .i_x      (ang_x),
        .i_z      (ang_z),
        .i_radius (r_radius),
        .o_done   (ang_done),
        .o_angle  (ang)
    );

endmodule
